// ===== hdl/swst_pkg.sv =====
// Package for the sliding window statistics block: payload types, state codes, sizes.
`timescale 1ns / 1ps
package swst_pkg;

	localparam int DEF_MAX_WINDOW = 64;
	localparam int PRICE_W        = 16;
	localparam int MEDIAN_W       = 17;
	localparam int MEAN_W         = 24;
	localparam int CFG_W          = 7;
	localparam int FRAC_W         = 8;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               start_new;
	} swst_in_t;

	typedef struct packed {
		logic [PRICE_W-1:0]  max_price;
		logic [PRICE_W-1:0]  min_price;
		logic [MEDIAN_W-1:0] median_halves;
		logic [MEAN_W-1:0]   mean_q8;
	} swst_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRIM,
		S_DROP,
		S_SCAN,
		S_DIV,
		S_EMIT
	} swst_state_t;

endpackage

// ===== hdl/swst_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module swst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/sliding_window_stats.sv =====
// Top level: sample ring, running sum, radix median search and serial mean divider.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   in_data   (price, start_new)
//  out       output     out_valid / out_stall out_data  (max, min, median, mean)
//  cfg       input      cfg_we                cfg_wdata (window length)
//
// For each item, with L = effective window length: the sample is written into the ring,
// the oldest samples beyond L are dropped one at a time, then when the window is full
// the ring is read in 16 passes (one bit of the two middle ranks per pass, single RAM read port).
// The mean divider (one bit per cycle) runs beside the passes.
// Reset clears counts, sum and handshake state; the ring needs no clearing.
// A stalled output holds the block before it drops the oldest sample.
`timescale 1ns / 1ps
module sliding_window_stats #(
	parameter int MAX_WINDOW = swst_pkg::DEF_MAX_WINDOW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  swst_pkg::swst_in_t        in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output swst_pkg::swst_out_t       out_data,
	input  logic                      cfg_we,
	input  logic [swst_pkg::CFG_W-1:0] cfg_wdata
);

	import swst_pkg::*;

	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam int SUM_W  = PRICE_W + $clog2(MAX_WINDOW);
	localparam int DIV_W  = SUM_W + FRAC_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	// ring slot = (base + offset) mod window capacity
	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
			input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = (LEN_W+1)'(a) + (LEN_W+1)'(b);
		if (s >= (LEN_W+1)'(MAX_WINDOW)) begin
			s = s - (LEN_W+1)'(MAX_WINDOW);
		end
		return s[AW-1:0];
	endfunction

	swst_state_t         state_q, state_d;
	logic [CFG_W-1:0]    wlen_q;
	logic [LEN_W-1:0]    fill_q;
	logic [AW-1:0]       oldest_q;
	logic [SUM_W-1:0]    sum_q;

	logic [LEN_W-1:0]    iss_q;
	logic                vld_q;
	logic [PRICE_W-1:0]  bit_q, mask_q;
	logic [PRICE_W-1:0]  pa_q, pb_q, max_q, min_q;
	logic [LEN_W-1:0]    ka_q, kb_q, cnta_q, cntb_q;
	logic [LEN_W-1:0]    rem_q;
	logic [DIV_W-1:0]    dq_q;
	logic [DCNT_W-1:0]   dcnt_q;

	swst_out_t           out_q;
	logic                out_valid_q;

	logic [LEN_W-1:0]    len;
	logic [CMP_W-1:0]    wl_ext;
	logic                in_xfer, out_free, pass_done;
	logic [LEN_W-1:0]    base_fill;
	logic [AW-1:0]       base_oldest;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [PRICE_W-1:0]  rd_data;
	logic                match_a, match_b;
	logic [LEN_W:0]      div_trial;

	// effective length, saturated to 1..MAX_WINDOW
	always_comb begin
		wl_ext = CMP_W'(wlen_q);
		if (wl_ext == '0) begin
			len = LEN_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(wl_ext);
		end
	end

	assign in_xfer     = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign pass_done   = (iss_q == len) && !vld_q;
	assign base_fill   = in_data.start_new ? '0 : fill_q;
	assign base_oldest = in_data.start_new ? '0 : oldest_q;
	assign match_a     = (((rd_data ^ pa_q) & mask_q) == '0) && ((rd_data & bit_q) == '0);
	assign match_b     = (((rd_data ^ pb_q) & mask_q) == '0) && ((rd_data & bit_q) == '0);
	assign div_trial   = {rem_q, dq_q[DIV_W-1]};

	swst_ram #(
		.WIDTH(PRICE_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_data.price),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) state_d = S_TRIM;
			end
			S_TRIM: begin
				if (fill_q > len) begin
					state_d = S_DROP;
				end else if (fill_q < len) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_DROP: state_d = S_TRIM;
			S_SCAN: begin
				if (pass_done && bit_q[0]) state_d = S_DIV;
			end
			S_DIV: begin
				if (dcnt_q == '0) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) state_d = S_DROP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake and ring port control
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = slot_add(base_oldest, base_fill);
		ram_raddr = oldest_q;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				ram_we   = in_valid;
			end
			S_SCAN:  ram_raddr = slot_add(oldest_q, iss_q);
			default: ram_raddr = oldest_q;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wlen_q      <= CFG_W'(1);
			fill_q      <= '0;
			oldest_q    <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) wlen_q <= cfg_wdata;
			// result register: set on emit, cleared once taken
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// divider bit counter, loaded when the window is complete
			if (state_q == S_TRIM && fill_q == len) begin
				dcnt_q <= DCNT_W'(DIV_W);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						fill_q   <= base_fill + LEN_W'(1);
						oldest_q <= base_oldest;
						sum_q    <= (in_data.start_new ? '0 : sum_q) + SUM_W'(in_data.price);
					end
				end
				S_DROP: begin
					sum_q    <= sum_q - SUM_W'(rd_data);
					oldest_q <= slot_add(oldest_q, LEN_W'(1));
					fill_q   <= fill_q - LEN_W'(1);
				end
				default: ;
			endcase
		end
	end

	// scan and divider datapath
	always_ff @(posedge clk) begin
		// restoring division, one quotient bit per cycle
		if (dcnt_q != '0) begin
			if (div_trial >= {1'b0, len}) begin
				rem_q <= LEN_W'(div_trial - {1'b0, len});
				dq_q  <= {dq_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= div_trial[LEN_W-1:0];
				dq_q  <= {dq_q[DIV_W-2:0], 1'b0};
			end
		end
		case (state_q)
			S_TRIM: begin
				iss_q  <= '0;
				vld_q  <= 1'b0;
				bit_q  <= {1'b1, {(PRICE_W-1){1'b0}}};
				mask_q <= '0;
				pa_q   <= '0;
				pb_q   <= '0;
				ka_q   <= (len - LEN_W'(1)) >> 1;
				kb_q   <= len >> 1;
				cnta_q <= '0;
				cntb_q <= '0;
				max_q  <= '0;
				min_q  <= '1;
				rem_q  <= '0;
				dq_q   <= {sum_q, {FRAC_W{1'b0}}};
			end
			S_SCAN: begin
				// issue ring reads, one per cycle
				if (iss_q < len) iss_q <= iss_q + LEN_W'(1);
				vld_q <= (iss_q < len);
				// count samples under each prefix with the current bit clear
				if (vld_q) begin
					if (rd_data > max_q) max_q <= rd_data;
					if (rd_data < min_q) min_q <= rd_data;
					if (match_a) cnta_q <= cnta_q + LEN_W'(1);
					if (match_b) cntb_q <= cntb_q + LEN_W'(1);
				end
				// settle one bit of both ranks
				if (pass_done) begin
					if (ka_q >= cnta_q) begin
						pa_q <= pa_q | bit_q;
						ka_q <= ka_q - cnta_q;
					end
					if (kb_q >= cntb_q) begin
						pb_q <= pb_q | bit_q;
						kb_q <= kb_q - cntb_q;
					end
					cnta_q <= '0;
					cntb_q <= '0;
					iss_q  <= '0;
					mask_q <= mask_q | bit_q;
					bit_q  <= bit_q >> 1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_q.max_price     <= max_q;
					out_q.min_price     <= min_q;
					out_q.median_halves <= MEDIAN_W'(pa_q) + MEDIAN_W'(pb_q);
					out_q.mean_q8       <= dq_q[MEAN_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(MAX_WINDOW))
		else $error("fill count above capacity");
	a_fill_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (fill_q != '0))
		else $error("window empty after a sample was taken");
	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (fill_q == len))
		else $error("scan over a window that is not full");
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

endmodule
